[sv/cpp_pkg.sv]
// Shared types, constants and direction tables for circle_pair_pushout.
package cpp_pkg;

  // Fraction bits of the position format
  localparam int PosFracBits = 16;
  // Width of the radius sum, the distance and the overlap in position units
  localparam int SumW        = PosFracBits + 8;
  localparam int PushShift   = PosFracBits - 8;
  localparam int NearLim     = ((1 << PosFracBits) + 5000) / 10000;

  localparam int DirSteps    = 17;   // quotient bits of the unit direction
  localparam int MassSteps   = 33;   // quotient bits of the mass split

  localparam logic [23:0] MassMin     = 24'd655;
  localparam logic [15:0] StiffReset  = 16'd256;

  // Fallback directions for nearly coincident bodies, signed Q1.16
  localparam logic signed [17:0] DirCos [8] = '{
    18'sd65536, 18'sd46341, 18'sd0, -18'sd46341,
    -18'sd65536, -18'sd46341, 18'sd0, 18'sd46341
  };
  localparam logic signed [17:0] DirSin [8] = '{
    18'sd0, 18'sd46341, 18'sd65536, 18'sd46341,
    18'sd0, -18'sd46341, -18'sd65536, -18'sd46341
  };

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_z;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_z;
    logic [15:0]        a_width;
    logic [15:0]        b_width;
    logic [23:0]        a_mass;
    logic [23:0]        b_mass;
    logic [2:0]         a_id_low;
    logic [2:0]         b_id_low;
  } in_t;

  typedef struct packed {
    logic               overlapping;
    logic signed [31:0] a_dvel_x;
    logic signed [31:0] a_dvel_z;
    logic signed [31:0] b_dvel_x;
    logic signed [31:0] b_dvel_z;
  } out_t;

  // Per-pair context carried down the pipeline
  typedef struct packed {
    logic                 ov;
    logic                 big;
    logic                 ax_neg;
    logic                 az_neg;
    logic [SumW-1:0]      ax;
    logic [SumW-1:0]      az;
    logic [SumW-1:0]      s;
    logic [SumW-1:0]      root;
    logic [SumW-1:0]      ovl;
    logic [2:0]           k;
    logic [23:0]          ma;
    logic [23:0]          mb;
    logic [24:0]          total;
    logic [2*SumW-1:0]    sx;
    logic [2*SumW-1:0]    sz;
    logic [2*SumW-1:0]    ss;
    logic [2*SumW-1:0]    d2;
    logic [SumW+1:0]      sq_rem;
    logic                 near;
    logic [SumW-1:0]      rx;
    logic [SumW-1:0]      rz;
    logic                 nbit_x;
    logic                 nbit_z;
    logic [DirSteps-1:0]  qx;
    logic [DirSteps-1:0]  qz;
    logic [31:0]          push;
    logic [16:0]          dxm;
    logic [16:0]          dzm;
    logic                 dxneg;
    logic                 dzneg;
    logic [32:0]          fx;
    logic [32:0]          fz;
    logic [3:0][24:0]     mrem;
    logic [3:0][32:0]     msh;
  } ctx_t;

endpackage

[sv/cpp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module cpp_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cpp_pkg::ctx_t   ctx_i,
  output logic            valid_o,
  output cpp_pkg::ctx_t   ctx_o
);

  localparam int W = cpp_pkg::SumW;

  cpp_pkg::ctx_t stg_q [W];
  cpp_pkg::ctx_t stg_d [W];
  logic [W-1:0]  vld_q;

  // One digit pair of the radicand per step; radicand shifts out at the top
  function automatic cpp_pkg::ctx_t sq_step(input cpp_pkg::ctx_t c);
    cpp_pkg::ctx_t  n;
    logic [W+3:0]   t;
    logic [W+3:0]   trial;
    logic           ge;
    n     = c;
    t     = {c.sq_rem, c.d2[2*W-1 -: 2]};
    trial = {2'b00, c.root, 2'b01};
    ge    = (t >= trial);
    n.sq_rem = ge ? (W+2)'(t - trial) : t[W+1:0];
    n.root   = {c.root[W-2:0], ge};
    n.d2     = {c.d2[2*W-3:0], 2'b00};
    return n;
  endfunction

  always_comb begin
    for (int i = 0; i < W; i++) begin
      stg_d[i] = sq_step((i == 0) ? ctx_i : stg_q[(i == 0) ? 0 : i - 1]);
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < W; i++) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[W-1];
  assign ctx_o   = stg_q[W-1];

endmodule

[sv/circle_pair_pushout.sv]
// Top level: pipelined mass-weighted pushout of one overlapping body pair.
//
// Takes one candidate pair per clock and returns one transaction per pair, in order. The
// pipeline length is set by the bit-serial square root (one root bit per stage) and by the two
// long-division chains: the unit direction (17 quotient bits) and the inverse mass split
// (33 quotient bits, four lanes). A stall on the output holds the whole pipeline; while the
// output is taken each cycle, a new pair enters each cycle. The user must write stiffness
// through cfg_we_i / cfg_wdata_i only while the pipeline is empty; the block itself does
// not enforce this.
module circle_pair_pushout (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cpp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cpp_pkg::out_t  out_data_o
);

  localparam int SW = cpp_pkg::SumW;
  localparam int DS = cpp_pkg::DirSteps;
  localparam int MS = cpp_pkg::MassSteps;

  logic          en;
  logic [15:0]   stiff_q;

  cpp_pkg::ctx_t st_a_d, st_a_q, st_b_d, st_b_q, st_c_d, st_c_q;
  cpp_pkg::ctx_t st_d_d, st_d_q, st_e_d, st_e_q, st_f_d, st_f_q;
  cpp_pkg::ctx_t sq_ctx;
  cpp_pkg::ctx_t dd_d [DS];
  cpp_pkg::ctx_t dd_q [DS];
  cpp_pkg::ctx_t md_d [MS];
  cpp_pkg::ctx_t md_q [MS];
  logic          va_q, vb_q, vc_q, vd_q, ve_q, vf_q, sq_vld;
  logic [DS-1:0] vdd_q;
  logic [MS-1:0] vmd_q;
  cpp_pkg::out_t out_d, out_q;
  logic          out_vld_q;

  // Whole pipeline advances unless a result waits on the output
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // Stiffness register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= cpp_pkg::StiffReset;
    end else if (cfg_we_i) begin
      stiff_q <= cfg_wdata_i;
    end
  end

  // Direction divider step: restoring, one quotient bit
  function automatic cpp_pkg::ctx_t dir_step(input cpp_pkg::ctx_t c);
    cpp_pkg::ctx_t n;
    logic [SW:0]   tx;
    logic [SW:0]   tz;
    logic          gx;
    logic          gz;
    n  = c;
    tx = {c.rx, c.nbit_x};
    tz = {c.rz, c.nbit_z};
    gx = (tx >= {1'b0, c.root});
    gz = (tz >= {1'b0, c.root});
    n.rx     = gx ? SW'(tx - {1'b0, c.root}) : tx[SW-1:0];
    n.rz     = gz ? SW'(tz - {1'b0, c.root}) : tz[SW-1:0];
    n.qx     = {c.qx[DS-2:0], gx};
    n.qz     = {c.qz[DS-2:0], gz};
    n.nbit_x = 1'b0;
    n.nbit_z = 1'b0;
    return n;
  endfunction

  // Mass split divider step over four lanes, quotient shifts into msh
  function automatic cpp_pkg::ctx_t mass_step(input cpp_pkg::ctx_t c);
    cpp_pkg::ctx_t n;
    logic [25:0]   t;
    logic          ge;
    n = c;
    for (int l = 0; l < 4; l++) begin
      t         = {c.mrem[l], c.msh[l][32]};
      ge        = (t >= {1'b0, c.total});
      n.mrem[l] = ge ? 25'(t - {1'b0, c.total}) : t[24:0];
      n.msh[l]  = {c.msh[l][31:0], ge};
    end
    return n;
  endfunction

  // Final sign and saturation of one nudge
  function automatic logic [31:0] sat_nudge(input logic [32:0] mag, input logic neg);
    logic [32:0] m;
    if (neg) begin
      m = (mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : mag;
      return 32'(33'd0 - m);
    end
    m = (mag > 33'h0_7FFF_FFFF) ? 33'h0_7FFF_FFFF : mag;
    return m[31:0];
  endfunction

  // Stage A: differences, magnitudes, radius sum, clamped masses
  always_comb begin
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [32:0]        ax;
    logic [32:0]        az;
    logic [16:0]        wsum;
    logic [16+cpp_pkg::PosFracBits:0] wsh;
    st_a_d = '0;
    dx   = {in_data_i.b_pos_x[31], in_data_i.b_pos_x} - {in_data_i.a_pos_x[31], in_data_i.a_pos_x};
    dz   = {in_data_i.b_pos_z[31], in_data_i.b_pos_z} - {in_data_i.a_pos_z[31], in_data_i.a_pos_z};
    ax   = dx[32] ? 33'(-dx) : 33'(dx);
    az   = dz[32] ? 33'(-dz) : 33'(dz);
    wsum = {1'b0, in_data_i.a_width} + {1'b0, in_data_i.b_width};
    wsh  = {wsum, {cpp_pkg::PosFracBits{1'b0}}};
    st_a_d.ax_neg = dx[32];
    st_a_d.az_neg = dz[32];
    st_a_d.big    = (|ax[32:SW]) || (|az[32:SW]);
    st_a_d.ax     = ax[SW-1:0];
    st_a_d.az     = az[SW-1:0];
    st_a_d.s      = wsh[16+cpp_pkg::PosFracBits:9];
    st_a_d.k      = in_data_i.a_id_low ^ in_data_i.b_id_low;
    st_a_d.ma     = (in_data_i.a_mass < cpp_pkg::MassMin) ? cpp_pkg::MassMin : in_data_i.a_mass;
    st_a_d.mb     = (in_data_i.b_mass < cpp_pkg::MassMin) ? cpp_pkg::MassMin : in_data_i.b_mass;
    st_a_d.total  = {1'b0, st_a_d.ma} + {1'b0, st_a_d.mb};
  end

  // Stage B: squares
  always_comb begin
    st_b_d    = st_a_q;
    st_b_d.sx = st_a_q.ax * st_a_q.ax;
    st_b_d.sz = st_a_q.az * st_a_q.az;
    st_b_d.ss = st_a_q.s * st_a_q.s;
  end

  // Stage C: squared distance and overlap test, root init
  always_comb begin
    logic [2*SW:0] sum;
    st_c_d        = st_b_q;
    sum           = {1'b0, st_b_q.sx} + {1'b0, st_b_q.sz};
    st_c_d.ov     = !st_b_q.big && (sum < {1'b0, st_b_q.ss});
    st_c_d.d2     = sum[2*SW-1:0];
    st_c_d.sq_rem = '0;
    st_c_d.root   = '0;
  end

  cpp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc_q),
    .ctx_i   (st_c_q),
    .valid_o (sq_vld),
    .ctx_o   (sq_ctx)
  );

  // Stage D: overlap, push, near test, divider init
  always_comb begin
    logic [SW+15:0] prod;
    st_d_d        = sq_ctx;
    st_d_d.ovl    = sq_ctx.s - sq_ctx.root;
    prod          = st_d_d.ovl * stiff_q;
    st_d_d.push   = prod[SW+15:cpp_pkg::PushShift];
    st_d_d.near   = (sq_ctx.root < SW'(cpp_pkg::NearLim)) || (sq_ctx.root == '0);
    st_d_d.rx     = {1'b0, sq_ctx.ax[SW-1:1]};
    st_d_d.rz     = {1'b0, sq_ctx.az[SW-1:1]};
    st_d_d.nbit_x = sq_ctx.ax[0];
    st_d_d.nbit_z = sq_ctx.az[0];
    st_d_d.qx     = '0;
    st_d_d.qz     = '0;
  end

  // Direction divider chain
  always_comb begin
    for (int i = 0; i < DS; i++) begin
      dd_d[i] = dir_step((i == 0) ? st_d_q : dd_q[(i == 0) ? 0 : i - 1]);
    end
  end

  // Stage E: pick direction, scale push by it
  always_comb begin
    logic signed [17:0] c;
    logic signed [17:0] sn;
    logic [48:0]        px;
    logic [48:0]        pz;
    st_e_d = dd_q[DS-1];
    c      = cpp_pkg::DirCos[dd_q[DS-1].k];
    sn     = cpp_pkg::DirSin[dd_q[DS-1].k];
    if (dd_q[DS-1].near) begin
      st_e_d.dxneg = c[17];
      st_e_d.dzneg = sn[17];
      st_e_d.dxm   = c[17] ? 17'(-c) : c[16:0];
      st_e_d.dzm   = sn[17] ? 17'(-sn) : sn[16:0];
    end else begin
      st_e_d.dxneg = dd_q[DS-1].ax_neg;
      st_e_d.dzneg = dd_q[DS-1].az_neg;
      st_e_d.dxm   = dd_q[DS-1].qx;
      st_e_d.dzm   = dd_q[DS-1].qz;
    end
    px        = dd_q[DS-1].push * st_e_d.dxm;
    pz        = dd_q[DS-1].push * st_e_d.dzm;
    st_e_d.fx = px[48:16];
    st_e_d.fz = pz[48:16];
  end

  // Stage F: weight by the other body's mass, divider init
  always_comb begin
    logic [3:0][56:0] p;
    st_f_d = st_e_q;
    p[0]   = st_e_q.fx * st_e_q.mb;
    p[1]   = st_e_q.fz * st_e_q.mb;
    p[2]   = st_e_q.fx * st_e_q.ma;
    p[3]   = st_e_q.fz * st_e_q.ma;
    for (int l = 0; l < 4; l++) begin
      st_f_d.mrem[l] = {1'b0, p[l][56:33]};
      st_f_d.msh[l]  = p[l][32:0];
    end
  end

  // Mass split divider chain
  always_comb begin
    for (int i = 0; i < MS; i++) begin
      md_d[i] = mass_step((i == 0) ? st_f_q : md_q[(i == 0) ? 0 : i - 1]);
    end
  end

  // Output stage: signs, saturation, clear on no overlap
  always_comb begin
    cpp_pkg::ctx_t c;
    c = md_q[MS-1];
    out_d = '0;
    if (c.ov) begin
      out_d.overlapping = 1'b1;
      out_d.a_dvel_x    = sat_nudge(c.msh[0], !c.dxneg);
      out_d.a_dvel_z    = sat_nudge(c.msh[1], !c.dzneg);
      out_d.b_dvel_x    = sat_nudge(c.msh[2], c.dxneg);
      out_d.b_dvel_z    = sat_nudge(c.msh[3], c.dzneg);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_a_q <= st_a_d;
      st_b_q <= st_b_d;
      st_c_q <= st_c_d;
      st_d_q <= st_d_d;
      st_e_q <= st_e_d;
      st_f_q <= st_f_d;
      out_q  <= out_d;
      for (int i = 0; i < DS; i++) begin
        dd_q[i] <= dd_d[i];
      end
      for (int i = 0; i < MS; i++) begin
        md_q[i] <= md_d[i];
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
      vd_q      <= 1'b0;
      ve_q      <= 1'b0;
      vf_q      <= 1'b0;
      vdd_q     <= '0;
      vmd_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      va_q      <= in_valid_i;
      vb_q      <= va_q;
      vc_q      <= vb_q;
      vd_q      <= sq_vld;
      vdd_q     <= {vdd_q[DS-2:0], vd_q};
      ve_q      <= vdd_q[DS-1];
      vf_q      <= ve_q;
      vmd_q     <= {vmd_q[MS-2:0], vf_q};
      out_vld_q <= vmd_q[MS-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // No overlap means no nudge at all
  a_clear_nudges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.overlapping |->
      (out_data_o.a_dvel_x == 0) && (out_data_o.a_dvel_z == 0) &&
      (out_data_o.b_dvel_x == 0) && (out_data_o.b_dvel_z == 0))
    else $error("nudge without overlap");

  // The two bodies are pushed apart along x
  a_opposite_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.a_dvel_x != 0) && (out_data_o.b_dvel_x != 0) |->
      out_data_o.a_dvel_x[31] != out_data_o.b_dvel_x[31])
    else $error("x nudges share a sign");

  // A stall freezes the pipeline occupancy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vdd_q) && $stable(vmd_q) && $stable(sq_vld))
    else $error("pipeline moved during stall");
`endif

endmodule

[tb/tb.sv]
// Testbench for circle_pair_pushout: directed and random body pairs checked against a predictor.
module tb;

  localparam int ClkPeriod = 12;
  localparam int PipeDrain = 90;   // pipeline is 81 stages deep

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [15:0]   cfg_wdata_i;
  logic          in_valid_i;
  logic          in_ready_o;
  cpp_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  cpp_pkg::out_t out_data_o;

  circle_pair_pushout DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  logic [15:0]   stiff_gain;        // predictor copy of the stiffness register
  cpp_pkg::out_t nudge_q[$];        // expected transactions, oldest first
  int            fail_cnt = 0;
  int            send_idle_pct;
  int            recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #(ClkPeriod * 3_000_000);
    $display("tb failed");
    $finish;
  end

  // Saturated signed nudge along one axis
  function automatic logic [31:0] axis_nudge(logic [63:0] push, logic [63:0] dmag, bit neg,
                                             logic [63:0] m, logic [63:0] total);
    logic [63:0] f;
    logic [63:0] mag;
    f   = (push * dmag) >> 16;
    mag = f * m / total;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Expected separation nudges for one pair
  function automatic cpp_pkg::out_t predict_pushout(cpp_pkg::in_t p);
    longint        dx, dz, cx, sz;
    logic [63:0]   ax, az, s, root, t, ovl, push, ma, mb, dxm, dzm;
    logic [64:0]   d2;
    bit            dxneg, dzneg;
    int            k;
    cpp_pkg::out_t r;
    r  = '0;
    dx = longint'(p.b_pos_x) - longint'(p.a_pos_x);
    dz = longint'(p.b_pos_z) - longint'(p.a_pos_z);
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    d2 = {1'b0, ax * ax} + {1'b0, az * az};
    s  = ((64'(p.a_width) + 64'(p.b_width)) << cpp_pkg::PosFracBits) >> 9;
    if (d2 >= {1'b0, s * s}) return r;
    // integer square root, one bit at a time
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= d2[63:0]) root = t;
    end
    ovl = s - root;
    if (root < cpp_pkg::NearLim || root == 0) begin
      k     = int'(p.a_id_low ^ p.b_id_low);
      cx    = longint'(cpp_pkg::DirCos[k]);
      sz    = longint'(cpp_pkg::DirSin[k]);
      dxm   = cx < 0 ? -cx : cx;
      dzm   = sz < 0 ? -sz : sz;
      dxneg = cx < 0;
      dzneg = sz < 0;
    end else begin
      dxm   = (ax << 16) / root;
      dzm   = (az << 16) / root;
      dxneg = dx < 0;
      dzneg = dz < 0;
    end
    ma   = p.a_mass < cpp_pkg::MassMin ? 64'(cpp_pkg::MassMin) : 64'(p.a_mass);
    mb   = p.b_mass < cpp_pkg::MassMin ? 64'(cpp_pkg::MassMin) : 64'(p.b_mass);
    push = (ovl * 64'(stiff_gain)) >> cpp_pkg::PushShift;
    r.overlapping = 1'b1;
    r.a_dvel_x = axis_nudge(push, dxm, !dxneg, mb, ma + mb);
    r.a_dvel_z = axis_nudge(push, dzm, !dzneg, mb, ma + mb);
    r.b_dvel_x = axis_nudge(push, dxm, dxneg, ma, ma + mb);
    r.b_dvel_z = axis_nudge(push, dzm, dzneg, ma, ma + mb);
    return r;
  endfunction

  function automatic cpp_pkg::in_t make_pair(int ax_i, int az_i, int bx_i, int bz_i, int aw,
                                             int bw, int am, int bm, int aid, int bid);
    cpp_pkg::in_t p;
    p.a_pos_x  = ax_i;
    p.a_pos_z  = az_i;
    p.b_pos_x  = bx_i;
    p.b_pos_z  = bz_i;
    p.a_width  = aw[15:0];
    p.b_width  = bw[15:0];
    p.a_mass   = am[23:0];
    p.b_mass   = bm[23:0];
    p.a_id_low = aid[2:0];
    p.b_id_low = bid[2:0];
    return p;
  endfunction

  // Random pair: mostly overlapping with random content, some arbitrary noise
  function automatic cpp_pkg::in_t random_pair();
    cpp_pkg::in_t p;
    logic [223:0] rnd;
    int           s, span;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    p   = cpp_pkg::in_t'(rnd[$bits(cpp_pkg::in_t)-1:0]);
    if ($urandom_range(99) < 15) return p;
    if ($urandom_range(3) == 0) begin
      p.a_width = 16'($urandom_range(2047));
      p.b_width = 16'($urandom_range(2047));
    end
    if ($urandom_range(7) == 0) p.a_mass = 24'($urandom_range(1000));
    if ($urandom_range(7) == 0) p.b_mass = 24'($urandom_range(1000));
    s = int'(((longint'(p.a_width) + longint'(p.b_width)) << cpp_pkg::PosFracBits) >>> 9);
    case ($urandom_range(9))
      0:       span = 3;
      1:       span = 12;
      default: span = s;
    endcase
    p.b_pos_x = p.a_pos_x + (int'($urandom_range(2 * span)) - span);
    p.b_pos_z = p.a_pos_z + (int'($urandom_range(2 * span)) - span);
    return p;
  endfunction

  // Send one transaction, then an optional gap
  task automatic send_pair(cpp_pkg::in_t p);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    nudge_q.push_back(predict_pushout(p));
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
  endtask

  // Wait until the pipeline is empty
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (nudge_q.size() != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic write_stiffness(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    stiff_gain = v;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker
  always @(posedge clk_i) begin
    cpp_pkg::out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (nudge_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_cnt++;
      end else begin
        e = nudge_q.pop_front();
        check_field("overlapping", 32'(e.overlapping), 32'(out_data_o.overlapping));
        check_field("a_dvel_x", e.a_dvel_x, out_data_o.a_dvel_x);
        check_field("a_dvel_z", e.a_dvel_z, out_data_o.a_dvel_z);
        check_field("b_dvel_x", e.b_dvel_x, out_data_o.b_dvel_x);
        check_field("b_dvel_z", e.b_dvel_z, out_data_o.b_dvel_z);
      end
    end
  end

  // Corner cases at reset stiffness
  task automatic test_directed();
    send_pair(make_pair(0, 0, 1 << 20, 0, 256, 256, 65536, 65536, 0, 0));
    send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                        65535, 65535, 65536, 65536, 0, 0));
    send_pair(make_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 65535, 65535, 1, 1, 7, 7));
    for (int k = 0; k < 8; k++)
      send_pair(make_pair(1000, -1000, 1000, -1000, 512, 256, 70000, 90000, k, 3));
    send_pair(make_pair(0, 0, 3, -2, 512, 512, 65536, 65536, 5, 1));
    send_pair(make_pair(0, 0, 131072, 0, 512, 512, 65536, 65536, 0, 0));
    send_pair(make_pair(0, 0, 131071, 0, 512, 512, 65536, 65536, 0, 0));
    send_pair(make_pair(0, 0, -40000, 30000, 512, 512, 0, 0, 0, 0));
    send_pair(make_pair(5, 5, 100, -9000, 1024, 300, 24'hFFFFFF, 654, 2, 6));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 65536, 65536, 0, 0));
    send_pair(make_pair(-7, 9, 20000, 20000, 65535, 65535, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    drain_pipe();
  endtask

  // Register extremes: zero gain and full gain with saturating nudges
  task automatic test_stiffness_extremes();
    write_stiffness(16'd0);
    send_pair(make_pair(0, 0, 5000, 5000, 4096, 4096, 65536, 65536, 0, 0));
    send_pair(make_pair(0, 0, 0, 0, 65535, 65535, 655, 24'hFFFFFF, 1, 0));
    drain_pipe();
    write_stiffness(16'hFFFF);
    send_pair(make_pair(0, 0, 0, 0, 65535, 65535, 0, 24'hFFFFFF, 1, 0));
    send_pair(make_pair(0, 0, 0, 0, 65535, 65535, 24'hFFFFFF, 0, 4, 0));
    send_pair(make_pair(0, 0, 70000, -70000, 65535, 65535, 655, 655, 0, 0));
    drain_pipe();
  endtask

  // One random phase at given idling rates
  task automatic test_random_pairs(int send_pct, int recv_pct, int n_items, logic [15:0] gain);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_stiffness(gain);
    for (int i = 0; i < n_items; i++) send_pair(random_pair());
    drain_pipe();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    stiff_gain     = cpp_pkg::StiffReset;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_stiffness_extremes();
    test_random_pairs(17, 55, 420, 16'(256 + $urandom_range(1024)));
    test_random_pairs(55, 17, 420, 16'($urandom));
    test_random_pairs(0, 0, 420, 16'd256);

    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
